/* design/ehd_pkg.sv */
package ehd_pkg;

    localparam int MAX_DEPTH   = 10;
    localparam int ADDR_BITS   = 24;
    localparam int IDX_W       = MAX_DEPTH;
    localparam int CNT_W       = MAX_DEPTH + 1;
    localparam int DEPTH_W     = 4;
    localparam int TABLE_CELLS = 1 << MAX_DEPTH;

    typedef enum logic [2:0] {
        OP_LOOKUP   = 3'd0,
        OP_SET      = 3'd1,
        OP_REMOVE   = 3'd2,
        OP_DOUBLE   = 3'd3,
        OP_COLLAPSE = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_RANGE  = 3'd1,
        ST_FULL   = 3'd2,
        ST_NOCOLL = 3'd3,
        ST_DEPTH  = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_RM_READ,
        S_FILL,
        S_DB_W0,
        S_DB_W1,
        S_CL_CHK,
        S_CL_GAP,
        S_CL_CP,
        S_RESULT
    } t_state;

endpackage

/* design/extendible_hash_directory.sv */
// Extendible-hashing directory: a 1024 x 24 bucket-address table in one
// synchronous memory (one read port, one write port) plus a global depth.
// One operation is taken at a time and gives one result beat. Errors and
// unknown codes go straight to the result; lookup reads one cell; set
// writes the cell range; remove reads the buddy cell and writes it into
// all 2^(global - local depth) cells of the bucket; double writes each
// cell into two; collapse compares the cell pairs, stopping on the first
// unequal pair, and when all are equal copies 2^(depth-1) cells down.
// A finished result waits in the output register while the next
// operation is taken.
module extendible_hash_directory (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [2:0]                    i_operation,
    input  logic [ehd_pkg::IDX_W-1:0]     i_cell_index,
    input  logic [ehd_pkg::IDX_W-1:0]     i_last_cell,
    input  logic [ehd_pkg::ADDR_BITS-1:0] i_new_bucket_address,
    input  logic [ehd_pkg::DEPTH_W-1:0]   i_local_depth,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ehd_pkg::ADDR_BITS-1:0] o_bucket_address,
    output logic                          o_changed,
    output logic [2:0]                    o_status,
    output logic [ehd_pkg::DEPTH_W-1:0]   o_global_depth
);
    import ehd_pkg::*;

    logic [ADDR_BITS-1:0] r_table [TABLE_CELLS];
    logic [ADDR_BITS-1:0] r_rd_data;

    t_state               r_state, n_state;
    logic [DEPTH_W-1:0]   r_depth, n_depth;
    logic [CNT_W-1:0]     r_ptr, n_ptr;
    logic [IDX_W-1:0]     r_last, n_last;
    logic [ADDR_BITS-1:0] r_data, n_data;
    logic [ADDR_BITS-1:0] r_res_addr, n_res_addr;
    logic                 r_res_changed, n_res_changed;
    t_status              r_res_status, n_res_status;
    logic                 r_out_valid, n_out_valid;
    logic [ADDR_BITS-1:0] r_out_addr, n_out_addr;
    logic                 r_out_changed, n_out_changed;
    t_status              r_out_status, n_out_status;
    logic [DEPTH_W-1:0]   r_out_depth, n_out_depth;

    logic                 is_accept;
    logic                 out_room;
    logic [CNT_W-1:0]     used;
    logic                 idx_oob;
    logic                 set_bad;
    logic                 depth_bad;
    logic                 full;
    logic [DEPTH_W-1:0]   rm_fill;
    logic [CNT_W-1:0]     rm_mask;
    logic [CNT_W-1:0]     rm_bit;
    logic [IDX_W-1:0]     rm_low;
    logic [IDX_W-1:0]     rm_high;
    logic [IDX_W-1:0]     rm_buddy;
    logic                 fill_done;
    logic                 db_done;
    logic                 chk_mismatch;
    logic                 chk_done;
    logic                 cp_done;
    logic [CNT_W-1:0]     ptr_dec;
    logic [CNT_W-1:0]     ptr_inc;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [ADDR_BITS-1:0] wr_data;
    logic [IDX_W-1:0]     rd_addr;

    assign o_stall   = (r_state != S_IDLE);
    assign is_accept = i_valid && (r_state == S_IDLE);
    assign out_room  = !r_out_valid || !i_stall;

    assign used      = CNT_W'(1) << r_depth;
    assign idx_oob   = {1'b0, i_cell_index} >= used;
    assign set_bad   = (i_cell_index > i_last_cell) || ({1'b0, i_last_cell} >= used);
    assign depth_bad = i_local_depth >= r_depth;
    assign full      = r_depth >= DEPTH_W'(MAX_DEPTH);

    // buddy differs in the highest fill bit; the bucket spans all fill bits
    assign rm_fill  = r_depth - i_local_depth;
    assign rm_mask  = (CNT_W'(1) << rm_fill) - CNT_W'(1);
    assign rm_bit   = CNT_W'(1) << (rm_fill - DEPTH_W'(1));
    assign rm_low   = i_cell_index & ~rm_mask[IDX_W-1:0];
    assign rm_high  = i_cell_index | rm_mask[IDX_W-1:0];
    assign rm_buddy = i_cell_index ^ rm_bit[IDX_W-1:0];

    assign ptr_dec      = r_ptr - CNT_W'(1);
    assign ptr_inc      = r_ptr + CNT_W'(1);
    assign fill_done    = (r_ptr[IDX_W-1:0] == r_last);
    assign db_done      = (r_ptr == '0);
    assign chk_mismatch = !r_ptr[0] && (r_rd_data != r_data);
    assign chk_done     = (r_ptr == used);
    assign cp_done      = (r_ptr == (used >> 1) - CNT_W'(1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (is_accept) begin
                    unique case (t_op'(i_operation))
                        OP_LOOKUP:   n_state = idx_oob ? S_RESULT : S_LOOK;
                        OP_SET:      n_state = set_bad ? S_RESULT : S_FILL;
                        OP_REMOVE:   n_state = (idx_oob || depth_bad) ? S_RESULT : S_RM_READ;
                        OP_DOUBLE:   n_state = full ? S_RESULT : S_DB_W0;
                        OP_COLLAPSE: n_state = (r_depth == '0) ? S_RESULT : S_CL_CHK;
                        default:     n_state = S_RESULT;
                    endcase
                end
            end
            S_LOOK:    n_state = S_RESULT;
            S_RM_READ: n_state = S_FILL;
            S_FILL:    n_state = fill_done ? S_RESULT : S_FILL;
            S_DB_W0:   n_state = S_DB_W1;
            S_DB_W1:   n_state = db_done ? S_RESULT : S_DB_W0;
            S_CL_CHK: begin
                if (chk_mismatch) begin
                    n_state = S_RESULT;
                end else if (!r_ptr[0] && chk_done) begin
                    n_state = S_CL_GAP;
                end
            end
            S_CL_GAP:  n_state = S_CL_CP;
            S_CL_CP:   n_state = cp_done ? S_RESULT : S_CL_CP;
            S_RESULT:  n_state = out_room ? S_IDLE : S_RESULT;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_depth       = r_depth;
        n_ptr         = r_ptr;
        n_last        = r_last;
        n_data        = r_data;
        n_res_addr    = r_res_addr;
        n_res_changed = r_res_changed;
        n_res_status  = r_res_status;
        n_out_valid   = r_out_valid && i_stall;
        n_out_addr    = r_out_addr;
        n_out_changed = r_out_changed;
        n_out_status  = r_out_status;
        n_out_depth   = r_out_depth;
        wr_en         = 1'b0;
        wr_addr       = r_ptr[IDX_W-1:0];
        wr_data       = r_data;
        rd_addr       = r_ptr[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                n_res_addr    = '0;
                n_res_changed = 1'b0;
                n_res_status  = ST_OK;
                unique case (t_op'(i_operation))
                    OP_LOOKUP: begin
                        rd_addr = i_cell_index;
                        if (idx_oob) n_res_status = ST_RANGE;
                    end
                    OP_SET: begin
                        n_ptr  = {1'b0, i_cell_index};
                        n_last = i_last_cell;
                        n_data = i_new_bucket_address;
                        if (set_bad) n_res_status = ST_RANGE;
                        else         n_res_changed = 1'b1;
                    end
                    OP_REMOVE: begin
                        rd_addr = rm_buddy;
                        n_ptr   = {1'b0, rm_low};
                        n_last  = rm_high;
                        if (idx_oob)        n_res_status = ST_RANGE;
                        else if (depth_bad) n_res_status = ST_DEPTH;
                        else                n_res_changed = 1'b1;
                    end
                    OP_DOUBLE: begin
                        n_ptr   = used - CNT_W'(1);
                        rd_addr = n_ptr[IDX_W-1:0];
                        if (full) n_res_status = ST_FULL;
                        else      n_res_changed = 1'b1;
                    end
                    OP_COLLAPSE: begin
                        rd_addr = '0;
                        n_ptr   = CNT_W'(1);
                        if (r_depth == '0) n_res_status = ST_NOCOLL;
                        else               n_res_changed = 1'b1;
                    end
                    default: ;
                endcase
            end
            S_LOOK: begin
                n_res_addr = r_rd_data;
            end
            S_RM_READ: begin
                n_res_addr = r_rd_data;
                n_data     = r_rd_data;
            end
            S_FILL: begin
                wr_en = 1'b1;
                n_ptr = ptr_inc;
            end
            S_DB_W0: begin
                // fetch the next lower cell while the pair is written
                wr_en   = 1'b1;
                wr_addr = {r_ptr[IDX_W-2:0], 1'b0};
                wr_data = r_rd_data;
                n_data  = r_rd_data;
                rd_addr = ptr_dec[IDX_W-1:0];
            end
            S_DB_W1: begin
                wr_en   = 1'b1;
                wr_addr = {r_ptr[IDX_W-2:0], 1'b1};
                rd_addr = ptr_dec[IDX_W-1:0];
                if (db_done) n_depth = r_depth + DEPTH_W'(1);
                else         n_ptr   = ptr_dec;
            end
            S_CL_CHK: begin
                // odd pointer: even cell just arrived; even pointer: odd cell
                n_ptr = ptr_inc;
                if (r_ptr[0]) begin
                    n_data = r_rd_data;
                end else if (chk_mismatch) begin
                    n_res_status  = ST_NOCOLL;
                    n_res_changed = 1'b0;
                end
            end
            S_CL_GAP: begin
                rd_addr = '0;
                n_ptr   = '0;
            end
            S_CL_CP: begin
                wr_en   = 1'b1;
                wr_data = r_rd_data;
                rd_addr = IDX_W'(ptr_inc << 1);
                if (cp_done) n_depth = r_depth - DEPTH_W'(1);
                else         n_ptr   = ptr_inc;
            end
            S_RESULT: begin
                if (out_room) begin
                    n_out_valid   = 1'b1;
                    n_out_addr    = r_res_addr;
                    n_out_changed = r_res_changed;
                    n_out_status  = r_res_status;
                    n_out_depth   = r_depth;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[wr_addr] <= wr_data;
        end
        r_rd_data <= r_table[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr         <= n_ptr;
        r_last        <= n_last;
        r_data        <= n_data;
        r_res_addr    <= n_res_addr;
        r_res_changed <= n_res_changed;
        r_res_status  <= n_res_status;
        r_out_addr    <= n_out_addr;
        r_out_changed <= n_out_changed;
        r_out_status  <= n_out_status;
        r_out_depth   <= n_out_depth;
    end

    assign o_valid          = r_out_valid;
    assign o_bucket_address = r_out_addr;
    assign o_changed        = r_out_changed;
    assign o_status         = r_out_status;
    assign o_global_depth   = r_out_depth;

endmodule

/* design/ehd_checker.sv */
module ehd_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          o_stall,
    input  logic [2:0]                    i_operation,
    input  logic [ehd_pkg::IDX_W-1:0]     i_cell_index,
    input  logic [ehd_pkg::IDX_W-1:0]     i_last_cell,
    input  logic [ehd_pkg::ADDR_BITS-1:0] i_new_bucket_address,
    input  logic [ehd_pkg::DEPTH_W-1:0]   i_local_depth,
    input  logic                          o_valid,
    input  logic                          i_stall,
    input  logic [ehd_pkg::ADDR_BITS-1:0] o_bucket_address,
    input  logic                          o_changed,
    input  logic [2:0]                    o_status,
    input  logic [ehd_pkg::DEPTH_W-1:0]   o_global_depth
);
    import ehd_pkg::*;

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_bucket_address)
            && $stable(o_changed) && $stable(o_status) && $stable(o_global_depth))
        else $error("result beat changed while stalled");

    // one operation at a time: an accepted beat closes the input side
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken while an operation is in flight");

    a_depth_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_global_depth <= DEPTH_W'(MAX_DEPTH))
        else $error("global depth beyond maximum");

    a_err_nochange: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> !o_changed)
        else $error("error status with table change");

    a_full_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> o_global_depth == DEPTH_W'(MAX_DEPTH))
        else $error("directory full reported below maximum depth");

endmodule

bind extendible_hash_directory ehd_checker u_ehd_checker (.*);
